// ===== src/tournament_tree_min_queue_core_macros.svh =====
// Assertion macros for the tournament tree minimum queue.
// Depends on nothing; the including module must provide clk and rst.
`ifndef TOURNAMENT_TREE_MIN_QUEUE_CORE_MACROS_SVH
`define TOURNAMENT_TREE_MIN_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ttmq_pkg.sv =====
// Shared constants, codes and helper functions of the tournament tree queue.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

package ttmq_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int KEY_BITS    = 32;
  localparam int CAPACITY    = 1 << TREE_LEVELS;
  localparam int SLOT_BITS   = TREE_LEVELS;
  localparam int NODE_BITS   = TREE_LEVELS + 1;
  localparam int COUNT_BITS  = TREE_LEVELS + 1;
  localparam int LVL_BITS    = $clog2(TREE_LEVELS + 1);
  localparam int NODE_DEPTH  = 1 << NODE_BITS;

  localparam logic [KEY_BITS-1:0] KEY_INF = '1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_BAD_SLOT = 2'd2
  } status_t;

  // Leftmost leaf index below node addr, which sits at level lvl (root is 0).
  function automatic logic [NODE_BITS-1:0] first_leaf(input logic [NODE_BITS-1:0] addr,
                                                      input logic [LVL_BITS-1:0]  lvl);
    logic [NODE_BITS-1:0] off;
    logic [LVL_BITS-1:0]  sh;
    off = addr & ~(NODE_BITS'(1) << lvl);
    sh  = LVL_BITS'(TREE_LEVELS) - lvl;
    return off << sh;
  endfunction

  // A node whose whole subtree lies at or beyond the count holds infinity,
  // whatever the node memory says.
  function automatic logic node_void(input logic [NODE_BITS-1:0]  addr,
                                     input logic [LVL_BITS-1:0]   lvl,
                                     input logic [COUNT_BITS-1:0] count);
    return first_leaf(addr, lvl) >= count;
  endfunction

endpackage

`default_nettype wire

// ===== src/ttmq_ram.sv =====
// Generic simple dual-read RAM: one write port, two registered read ports.
// Depends on nothing.
`default_nettype none

module ttmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_a_addr,
  output logic      [WIDTH-1:0]     rd_a_data,
  input  wire logic [ADDR_BITS-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]     rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

// ===== src/tournament_tree_min_queue_core.sv =====
// Top level of the tournament tree minimum queue: sequencer, path refresh,
// minimum descent and result register. Depends on ttmq_pkg, ttmq_ram and the
// assertion macro header.
//
//   Channel  Handshake           Payload
//   -------  ------------------  ----------------------------------------------
//   input    in_valid/in_ready   action, slot, key
//   output   out_valid/out_ready min_slot, min_key, occupancy, is_empty, status
//
// Flow: a query or a refused action goes from the transfer straight to the
// minimum descent; an insert, an update or a remove of the last slot first
// writes the leaf and refreshes its path up to the root; a remove that moves
// the last key loads it, refreshes the removed slot's path, then blanks the
// old last leaf and refreshes again. The next transfer waits for idle. The
// node memory's write port and two read ports serve one tree level at a time.
// Reset clears the sequencer, the count, the remove flag and the result valid
// flag only: the node memory is never cleared, because any node whose leftmost
// leaf lies at or beyond the count is read as infinity.
// A stalled output does not stop the next transfer; only a finished result
// waits in the final state until the result register is free.
`default_nettype none
`include "tournament_tree_min_queue_core_macros.svh"

module tournament_tree_min_queue_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         action,
  input  wire logic [ttmq_pkg::SLOT_BITS-1:0]     slot,
  input  wire logic [ttmq_pkg::KEY_BITS-1:0]      key,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [ttmq_pkg::SLOT_BITS-1:0]     min_slot,
  output logic      [ttmq_pkg::KEY_BITS-1:0]      min_key,
  output logic      [ttmq_pkg::COUNT_BITS-1:0]    occupancy,
  output logic                                    is_empty,
  output logic      [1:0]                         status
);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // waiting for a transfer
    S_LOAD = 6'b000010,  // last key arrives from memory for a remove
    S_LEAF = 6'b000100,  // write the changed leaf, fetch its sibling
    S_UP   = 6'b001000,  // one tree level of path refresh per cycle
    S_DESC = 6'b010000,  // one tree level of minimum descent per cycle
    S_DONE = 6'b100000   // result ready, waiting for the result register
  } state_t;

  state_t                                state, state_next;
  logic [ttmq_pkg::COUNT_BITS-1:0]       count, count_next;
  logic [ttmq_pkg::NODE_BITS-1:0]        cur_addr, cur_addr_next;
  logic [ttmq_pkg::KEY_BITS-1:0]         cur_val, cur_val_next;
  logic [ttmq_pkg::LVL_BITS-1:0]         lvl, lvl_next;
  logic [ttmq_pkg::SLOT_BITS-1:0]        slot_hold, slot_hold_next;
  logic                                  rm_pending, rm_pending_next;
  logic                                  a_void, a_void_next;
  logic                                  b_void, b_void_next;
  ttmq_pkg::status_t                     sts, sts_next;

  logic                                  out_valid_next;
  logic [ttmq_pkg::SLOT_BITS-1:0]        min_slot_next;
  logic [ttmq_pkg::KEY_BITS-1:0]         min_key_next;
  logic [ttmq_pkg::COUNT_BITS-1:0]       occupancy_next;
  logic                                  is_empty_next;
  logic [1:0]                            status_next;

  // Node memory: node n lives at address n, root at 1, leaves from CAPACITY.
  logic                                  wr_en;
  logic [ttmq_pkg::NODE_BITS-1:0]        wr_addr;
  logic [ttmq_pkg::KEY_BITS-1:0]         wr_data;
  logic [ttmq_pkg::NODE_BITS-1:0]        rd_a_addr, rd_b_addr;
  logic [ttmq_pkg::KEY_BITS-1:0]         rd_a_data, rd_b_data;
  logic [ttmq_pkg::LVL_BITS-1:0]         rd_lvl;

  // Compare units and their operands: one for path refresh, one for descent.
  logic [ttmq_pkg::KEY_BITS-1:0]         a_val, b_val, sib_val, pmin;
  logic                                  pick_left;
  logic [ttmq_pkg::NODE_BITS-1:0]        child, parent;
  logic [ttmq_pkg::SLOT_BITS-1:0]        last_slot;
  logic                                  in_xfer;

  ttmq_ram #(
    .WIDTH (ttmq_pkg::KEY_BITS),
    .DEPTH (ttmq_pkg::NODE_DEPTH)
  ) u_nodes (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign last_slot = ttmq_pkg::SLOT_BITS'(count - 1'b1);

  // Masked memory data: a void node reads as infinity.
  assign a_val     = a_void ? ttmq_pkg::KEY_INF : rd_a_data;
  assign b_val     = b_void ? ttmq_pkg::KEY_INF : rd_b_data;
  assign sib_val   = a_val;
  assign pmin      = (cur_val <= sib_val) ? cur_val : sib_val;
  assign parent    = cur_addr >> 1;
  assign pick_left = (a_val <= b_val);
  assign child     = {cur_addr[ttmq_pkg::NODE_BITS-2:0], ~pick_left};

  always_comb begin
    state_next      = state;
    count_next      = count;
    cur_addr_next   = cur_addr;
    cur_val_next    = cur_val;
    lvl_next        = lvl;
    slot_hold_next  = slot_hold;
    rm_pending_next = rm_pending;
    sts_next        = sts;

    out_valid_next  = out_valid && !out_ready;
    min_slot_next   = min_slot;
    min_key_next    = min_key;
    occupancy_next  = occupancy;
    is_empty_next   = is_empty;
    status_next     = status;

    wr_en           = 1'b0;
    wr_addr         = cur_addr;
    wr_data         = cur_val;
    rd_a_addr       = cur_addr ^ ttmq_pkg::NODE_BITS'(1);
    rd_b_addr       = cur_addr;
    rd_lvl          = lvl;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          sts_next       = ttmq_pkg::STS_OK;
          slot_hold_next = slot;
          lvl_next       = ttmq_pkg::LVL_BITS'(ttmq_pkg::TREE_LEVELS);
          // Start the descent unless an action below changes the tree.
          state_next     = S_DESC;
          cur_addr_next  = ttmq_pkg::NODE_BITS'(1);
          rd_a_addr      = ttmq_pkg::NODE_BITS'(2);
          rd_b_addr      = ttmq_pkg::NODE_BITS'(3);
          rd_lvl         = ttmq_pkg::LVL_BITS'(1);
          unique case (ttmq_pkg::action_t'(action)) inside
            ttmq_pkg::ACT_INSERT: begin
              if (count == ttmq_pkg::COUNT_BITS'(ttmq_pkg::CAPACITY)) begin
                sts_next = ttmq_pkg::STS_FULL;
                lvl_next = ttmq_pkg::LVL_BITS'(1);
              end else begin
                cur_addr_next = {1'b1, ttmq_pkg::SLOT_BITS'(count)};
                cur_val_next  = key;
                count_next    = count + 1'b1;
                state_next    = S_LEAF;
              end
            end
            ttmq_pkg::ACT_UPDATE, ttmq_pkg::ACT_REMOVE: begin
              if ({1'b0, slot} >= count) begin
                sts_next = ttmq_pkg::STS_BAD_SLOT;
                lvl_next = ttmq_pkg::LVL_BITS'(1);
              end else if (action == ttmq_pkg::ACT_UPDATE) begin
                cur_addr_next = {1'b1, slot};
                cur_val_next  = key;
                state_next    = S_LEAF;
              end else if (slot != last_slot) begin
                // Fetch the last key; it moves into the removed slot.
                rd_a_addr  = {1'b1, last_slot};
                state_next = S_LOAD;
              end else begin
                // Removing the last slot: only blank it and shrink.
                cur_addr_next   = {1'b1, last_slot};
                cur_val_next    = ttmq_pkg::KEY_INF;
                count_next      = count - 1'b1;
                rm_pending_next = 1'b0;
                state_next      = S_LEAF;
              end
            end
            default: begin
              lvl_next = ttmq_pkg::LVL_BITS'(1);
            end
          endcase
        end
      end

      S_LOAD: begin
        cur_val_next    = rd_a_data;
        cur_addr_next   = {1'b1, slot_hold};
        rm_pending_next = 1'b1;
        state_next      = S_LEAF;
      end

      S_LEAF: begin
        wr_en      = 1'b1;
        state_next = S_UP;
      end

      S_UP: begin
        wr_en         = 1'b1;
        wr_addr       = parent;
        wr_data       = pmin;
        cur_addr_next = parent;
        cur_val_next  = pmin;
        lvl_next      = lvl - 1'b1;
        rd_a_addr     = parent ^ ttmq_pkg::NODE_BITS'(1);
        rd_lvl        = lvl - 1'b1;
        if (lvl == ttmq_pkg::LVL_BITS'(1)) begin
          if (rm_pending) begin
            // Second pass of a remove: blank the old last leaf.
            rm_pending_next = 1'b0;
            cur_addr_next   = {1'b1, last_slot};
            cur_val_next    = ttmq_pkg::KEY_INF;
            count_next      = count - 1'b1;
            lvl_next        = ttmq_pkg::LVL_BITS'(ttmq_pkg::TREE_LEVELS);
            state_next      = S_LEAF;
          end else begin
            cur_addr_next = ttmq_pkg::NODE_BITS'(1);
            lvl_next      = ttmq_pkg::LVL_BITS'(1);
            rd_a_addr     = ttmq_pkg::NODE_BITS'(2);
            rd_b_addr     = ttmq_pkg::NODE_BITS'(3);
            rd_lvl        = ttmq_pkg::LVL_BITS'(1);
            state_next    = S_DESC;
          end
        end
      end

      S_DESC: begin
        cur_addr_next = child;
        cur_val_next  = pick_left ? a_val : b_val;
        lvl_next      = lvl + 1'b1;
        rd_a_addr     = {child[ttmq_pkg::NODE_BITS-2:0], 1'b0};
        rd_b_addr     = {child[ttmq_pkg::NODE_BITS-2:0], 1'b1};
        rd_lvl        = lvl + 1'b1;
        if (lvl == ttmq_pkg::LVL_BITS'(ttmq_pkg::TREE_LEVELS)) begin
          lvl_next   = lvl;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          min_slot_next  = cur_addr[ttmq_pkg::SLOT_BITS-1:0];
          min_key_next   = cur_val;
          occupancy_next = count;
          is_empty_next  = (count == '0);
          status_next    = sts;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Void flags travel with the read they belong to; the count that applies
  // when the data arrives is the one being registered now.
  assign a_void_next = ttmq_pkg::node_void(rd_a_addr, rd_lvl, count_next);
  assign b_void_next = ttmq_pkg::node_void(rd_b_addr, rd_lvl, count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rm_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rm_pending <= rm_pending_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr  <= cur_addr_next;
    cur_val   <= cur_val_next;
    lvl       <= lvl_next;
    slot_hold <= slot_hold_next;
    sts       <= sts_next;
    a_void    <= a_void_next;
    b_void    <= b_void_next;
    min_slot  <= min_slot_next;
    min_key   <= min_key_next;
    occupancy <= occupancy_next;
    is_empty  <= is_empty_next;
    status    <= status_next;
  end

  `TTMQ_ASSERT_IMP(a_count_cap, 1'b1, count <= ttmq_pkg::COUNT_BITS'(ttmq_pkg::CAPACITY), "count beyond capacity")
  `TTMQ_ASSERT_NXT(a_insert_grows, in_xfer && action == ttmq_pkg::ACT_INSERT && count != ttmq_pkg::COUNT_BITS'(ttmq_pkg::CAPACITY), count == $past(count) + 1'b1, "insert did not grow the count")
  `TTMQ_ASSERT_IMP(a_no_node_zero, wr_en, wr_addr != '0, "write to unused node address")
  `TTMQ_ASSERT_IMP(a_finite_not_empty, out_valid && min_key != ttmq_pkg::KEY_INF, !is_empty, "finite minimum from an empty store")
  `TTMQ_ASSERT_IMP(a_desc_level, state == S_DESC, lvl != '0 && lvl <= ttmq_pkg::LVL_BITS'(ttmq_pkg::TREE_LEVELS), "descent level out of range")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the tournament tree minimum queue: a scoreboard
// predicts every result from its own copy of the stored keys.
// Depends on ttmq_pkg and the tournament_tree_min_queue_core top level.
`timescale 1ns / 100ps

module tb;
  import ttmq_pkg::*;

  // A run of cycles with no transfer on either channel reaching this is a hang.
  // The slowest action and the random stalls are far shorter, so this leaves a
  // wide margin.
  localparam int HANG_LIMIT   = 5000;
  // Printing stops after this many mismatch lines; counting goes on.
  localparam int PRINT_LIMIT  = 100;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    action_t              act;
    logic [SLOT_BITS-1:0] slot;
    logic [KEY_BITS-1:0]  key;
  } request_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  min_slot;
    logic [KEY_BITS-1:0]   min_key;
    logic [COUNT_BITS-1:0] occupancy;
    logic                  is_empty;
    status_t               status;
  } result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [1:0]            action    = ACT_QUERY;
  logic [SLOT_BITS-1:0]  slot      = '0;
  logic [KEY_BITS-1:0]   key       = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_BITS-1:0]  min_slot;
  logic [KEY_BITS-1:0]   min_key;
  logic [COUNT_BITS-1:0] occupancy;
  logic                  is_empty;
  logic [1:0]            status;

  tournament_tree_min_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .slot      (slot),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_slot  (min_slot),
    .min_key   (min_key),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .status    (status)
  );

  always #4 clk = ~clk;

  // Requests waiting to be driven, and results predicted but not yet seen.
  request_t pending_requests[$];
  result_t  awaited_minima[$];

  // The scoreboard's own picture of the store: dense keys and their count.
  logic [KEY_BITS-1:0] stored_keys[CAPACITY];
  int                  key_count = 0;

  // Occupancy as the stimulus generator expects it, ahead of the driver.
  int gen_count = 0;

  // Idling percentages of the current phase.
  int gap_pct   = 0;
  int stall_pct = 0;

  logic     in_fire = 1'b0;
  request_t next_request;
  int       quiet_cycles = 0;
  int       error_count  = 0;

  // Tallies for the closing summary.
  int act_seen[4];
  int refused_full  = 0;
  int refused_slot  = 0;
  int peak_count    = 0;
  int results_seen  = 0;

  initial begin
    for (int i = 0; i < CAPACITY; i++) stored_keys[i] = KEY_INF;
    for (int i = 0; i < 4; i++) act_seen[i] = 0;
  end

  // Apply one action to the scoreboard's store and return the minimum that
  // the block must report afterwards. The minimum is the leftmost smallest
  // key among the stored ones, which is exactly what a descent with left
  // preference on ties finds in a fully refreshed tree.
  function automatic result_t apply_to_store(input request_t req);
    result_t res;
    int      last;
    int      i;
    res.status = STS_OK;
    case (req.act)
      ACT_INSERT: begin
        if (key_count >= CAPACITY) begin
          res.status = STS_FULL;
        end else begin
          stored_keys[key_count] = req.key;
          key_count++;
        end
      end
      ACT_UPDATE, ACT_REMOVE: begin
        if (int'(req.slot) >= key_count) begin
          res.status = STS_BAD_SLOT;
        end else if (req.act == ACT_UPDATE) begin
          stored_keys[req.slot] = req.key;
        end else begin
          // The last key fills the hole; removing the last slot itself just
          // clears it.
          last = key_count - 1;
          stored_keys[req.slot] = stored_keys[last];
          stored_keys[last] = KEY_INF;
          key_count--;
        end
      end
      default: begin
      end
    endcase
    res.min_slot = '0;
    res.min_key  = KEY_INF;
    for (i = 0; i < key_count; i++) begin
      if (stored_keys[i] < res.min_key) begin
        res.min_slot = SLOT_BITS'(i);
        res.min_key  = stored_keys[i];
      end
    end
    res.occupancy = COUNT_BITS'(key_count);
    res.is_empty  = (key_count == 0);
    act_seen[req.act]++;
    if (res.status == STS_FULL) refused_full++;
    if (res.status == STS_BAD_SLOT) refused_slot++;
    if (key_count > peak_count) peak_count = key_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_BITS-1:0] got,
                                 input logic [KEY_BITS-1:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("ERROR %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Driver. Inputs change on the falling edge only. A new request is offered
  // once the previous one has completed its transfer, unless this cycle is
  // chosen as a sender gap; the payload then holds until the transfer.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        next_request = pending_requests.pop_front();
        in_valid <= 1'b1;
        action   <= next_request.act;
        slot     <= next_request.slot;
        key      <= next_request.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and scoreboard. Everything is sampled on the rising edge: an
  // accepted request is predicted at once, and an accepted result is
  // compared field by field with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready)
        awaited_minima.push_back(apply_to_store('{act: action_t'(action), slot: slot,
                                                  key: key}));
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_minima.size() == 0) begin
          report_mismatch("result with nothing awaited, min_key", min_key, KEY_INF);
        end else begin
          automatic result_t want = awaited_minima.pop_front();
          if (min_slot !== want.min_slot)
            report_mismatch("min_slot", KEY_BITS'(min_slot), KEY_BITS'(want.min_slot));
          if (min_key !== want.min_key)
            report_mismatch("min_key", min_key, want.min_key);
          if (occupancy !== want.occupancy)
            report_mismatch("occupancy", KEY_BITS'(occupancy), KEY_BITS'(want.occupancy));
          if (is_empty !== want.is_empty)
            report_mismatch("is_empty", KEY_BITS'(is_empty), KEY_BITS'(want.is_empty));
          if (status !== want.status)
            report_mismatch("status", KEY_BITS'(status), KEY_BITS'(want.status));
        end
      end
      // Watchdog: a long run of cycles with no transfer means a hang.
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                 HANG_LIMIT, awaited_minima.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Queue one request and track the occupancy it leaves behind.
  task automatic push_item(input action_t act, input int unsigned at,
                           input logic [KEY_BITS-1:0] k);
    pending_requests.push_back('{act: act, slot: SLOT_BITS'(at), key: k});
    if (act == ACT_INSERT && gen_count < CAPACITY) gen_count++;
    if (act == ACT_REMOVE && int'(at) < gen_count) gen_count--;
  endtask

  // Keys come from a small pool for frequent ties, from whole-number 16.16
  // values, from the extremes, or fully at random.
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_BITS'($urandom_range(0, 15));
      1: return KEY_BITS'($urandom_range(0, 255)) << 16;
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return KEY_INF;
          2: return KEY_INF - 1;
          default: return {1'b1, {(KEY_BITS-1){1'b0}}};
        endcase
      end
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Slots mostly name a stored key, often the last one, and now and then
  // any position at all so that out-of-range slots keep turning up.
  function automatic int unsigned pick_slot();
    if (gen_count == 0 || $urandom_range(0, 9) == 0)
      return $urandom_range(0, CAPACITY - 1);
    if ($urandom_range(0, 4) == 0)
      return gen_count - 1;
    return $urandom_range(0, gen_count - 1);
  endfunction

  // One random request; the caller sets how often inserts and removes occur,
  // and the remainder splits between updates and queries three to one.
  task automatic push_random(input int insert_pct, input int remove_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < insert_pct)
      push_item(ACT_INSERT, $urandom_range(0, CAPACITY - 1), pick_key());
    else if (p < insert_pct + remove_pct)
      push_item(ACT_REMOVE, pick_slot(), pick_key());
    else if ($urandom_range(0, 3) != 0)
      push_item(ACT_UPDATE, pick_slot(), pick_key());
    else
      push_item(ACT_QUERY, $urandom_range(0, CAPACITY - 1), pick_key());
  endtask

  // Block until every request has been transferred and every result seen.
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || awaited_minima.size() != 0)
      @(posedge clk);
  endtask

  // Random phase whose occupancy wanders around a target that moves every
  // few dozen requests, so the store keeps passing through empty and small.
  task automatic random_phase(input int gaps, input int stalls);
    int target;
    target = 0;
    gap_pct = gaps;
    stall_pct = stalls;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) target = $urandom_range(0, 48);
      push_random(gen_count < target ? 40 : 20, gen_count > target ? 40 : 15);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling: empty store, refused actions, extreme keys,
    // ties, increases and decreases, removal at the front and at the end.
    push_item(ACT_QUERY, 0, '0);
    push_item(ACT_REMOVE, 0, '0);
    push_item(ACT_UPDATE, CAPACITY - 1, '0);
    push_item(ACT_INSERT, 0, KEY_INF);
    push_item(ACT_INSERT, CAPACITY - 1, KEY_INF - 1);
    push_item(ACT_INSERT, 0, '0);
    push_item(ACT_INSERT, 0, '0);
    push_item(ACT_UPDATE, 2, 32'd5);
    push_item(ACT_UPDATE, 3, KEY_INF);
    push_item(ACT_UPDATE, 4, '0);
    push_item(ACT_REMOVE, CAPACITY - 1, '0);
    push_item(ACT_REMOVE, 0, '0);
    push_item(ACT_REMOVE, 2, '0);
    push_item(ACT_QUERY, CAPACITY - 1, KEY_INF);
    push_item(ACT_INSERT, 0, 32'h7fff_ffff);
    push_item(ACT_INSERT, 0, 32'h8000_0000);
    push_item(ACT_UPDATE, 0, 32'h0000_ffff);
    push_item(ACT_UPDATE, 1, 32'h0000_ffff);
    while (gen_count > 0) push_item(ACT_REMOVE, 0, '0);
    push_item(ACT_REMOVE, 0, '0);
    push_item(ACT_QUERY, 0, '0);
    drain();

    random_phase(59, 0);
    random_phase(0, 59);
    random_phase(9, 9);

    // Fill the store to capacity with mostly inserts, touching slots in the
    // upper half on the way, then knock on the full store.
    gap_pct = 0;
    stall_pct = 0;
    while (gen_count < CAPACITY) push_random(85, 5);
    push_item(ACT_INSERT, 0, '0);
    push_item(ACT_UPDATE, CAPACITY - 1, '0);
    push_item(ACT_QUERY, 0, '0);
    push_item(ACT_REMOVE, CAPACITY / 2, '0);
    push_item(ACT_INSERT, 0, KEY_INF);
    push_item(ACT_INSERT, 0, '0);
    push_item(ACT_REMOVE, CAPACITY - 1, '0);
    for (int n = 0; n < 30; n++) push_random(50, 25);
    drain();

    // Let any trailing activity in the block settle before the verdict.
    repeat (50) @(posedge clk);
    if (awaited_minima.size() != 0)
      report_mismatch("results never delivered", KEY_BITS'(awaited_minima.size()), '0);

    $display("Summary: %0d results checked; %0d inserts, %0d updates, %0d removes, %0d queries.",
             results_seen, act_seen[ACT_INSERT], act_seen[ACT_UPDATE],
             act_seen[ACT_REMOVE], act_seen[ACT_QUERY]);
    $display("Summary: %0d inserts refused as full, %0d bad slots, peak occupancy %0d.",
             refused_full, refused_slot, peak_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
